### design/sled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sled_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned LEN_W  = 5;

    localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;

    localparam logic [KIND_W-1:0] KIND_HEADER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERSIZE = 2'd2;

    typedef struct packed {
        logic wr;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### design/stx_len_etx_command_deframer_core.sv
// STX / opcode / length / payload / ETX command deframer.
// Input channel: one received byte per beat (in_valid, in_ready, byte_in).
// Output channel: one result per beat (out_valid, out_ready, kind, opcode,
// payload_len, data_byte, byte_index, last).
// Payload bytes are written into a row of byte cells indexed by the receive
// count; on ETX the row shifts toward cell 0 one byte per output beat.
// Latency: a header or oversize result is valid the cycle after the beat that
// causes it (the ETX or the length byte). Payload results follow at one per
// cycle while the receiver takes them.
// Throughput: one input byte per cycle outside of payload release. After a
// frame with N payload bytes closes, in_ready stays low for N output beats
// while the cell row drains; the rate there is set by the output handshake.
// in_ready is also low while a result sits in the output register unaccepted.
// A stalled receiver holds the output register and backs up into in_ready.
// Reset: parser waits for STX, output register empty; payload cells and the
// held opcode are not reset and are always written before they are read.
`timescale 1ns / 1ps
`default_nettype none
module stx_len_etx_command_deframer_core #(
    parameter int unsigned PAYLOAD_BUFFER_BYTES = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sled_pkg::BYTE_W-1:0] byte_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [sled_pkg::KIND_W-1:0] kind,
    output logic      [sled_pkg::BYTE_W-1:0] opcode,
    output logic      [sled_pkg::LEN_W-1:0]  payload_len,
    output logic      [sled_pkg::BYTE_W-1:0] data_byte,
    output logic      [sled_pkg::LEN_W-1:0]  byte_index,
    output logic                             last
);

    localparam int unsigned MaxPayload = PAYLOAD_BUFFER_BYTES - 2;
    localparam int unsigned CntW       = $clog2(MaxPayload + 1);

    typedef enum logic [6:0] {
        PH_WAIT_STX = 7'b0000001,
        PH_OPCODE   = 7'b0000010,
        PH_LENGTH   = 7'b0000100,
        PH_PAYLOAD  = 7'b0001000,
        PH_WAIT_ETX = 7'b0010000,
        PH_DISCARD  = 7'b0100000,
        PH_DRAIN    = 7'b1000000
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [CntW-1:0]             count_reg, count_next;
    logic [CntW-1:0]             len_reg, len_next;
    logic [CntW-1:0]             drain_idx_reg, drain_idx_next;
    logic [sled_pkg::BYTE_W-1:0] opcode_hold_reg, opcode_hold_next;

    logic                        out_valid_reg, out_valid_next;
    logic [sled_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [sled_pkg::BYTE_W-1:0] opcode_reg, opcode_next;
    logic [sled_pkg::LEN_W-1:0]  payload_len_reg, payload_len_next;
    logic [sled_pkg::BYTE_W-1:0] data_byte_reg, data_byte_next;
    logic [sled_pkg::LEN_W-1:0]  byte_index_reg, byte_index_next;
    logic                        last_reg, last_next;

    logic                        out_free;
    logic                        in_beat;
    logic                        payload_wr;
    logic                        drain_shift;
    logic [sled_pkg::BYTE_W-1:0] cell_q [MaxPayload];

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = out_free && (phase_reg != PH_DRAIN);
    assign in_beat  = in_valid && in_ready;

    // byte cell row
    for (genvar i = 0; i < MaxPayload; i++)
    begin : g_cell
        sled_pkg::cell_ctrl_t        ctrl;
        logic [sled_pkg::BYTE_W-1:0] nbr;

        assign ctrl.wr    = payload_wr && (count_reg == CntW'(i));
        assign ctrl.shift = drain_shift;

        if (i == MaxPayload - 1)
        begin : g_tail
            assign nbr = cell_q[i];
        end
        else
        begin : g_link
            assign nbr = cell_q[i+1];
        end

        sled_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .wr_data  (byte_in),
            .nbr_data (nbr),
            .q        (cell_q[i])
        );
    end

    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        len_next         = len_reg;
        drain_idx_next   = drain_idx_reg;
        opcode_hold_next = opcode_hold_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        kind_next        = kind_reg;
        opcode_next      = opcode_reg;
        payload_len_next = payload_len_reg;
        data_byte_next   = data_byte_reg;
        byte_index_next  = byte_index_reg;
        last_next        = last_reg;
        payload_wr       = 1'b0;
        drain_shift      = 1'b0;

        case (phase_reg)
            PH_WAIT_STX:
            begin
                if (in_beat && byte_in == sled_pkg::BYTE_STX)
                begin
                    count_next = '0;
                    phase_next = PH_OPCODE;
                end
            end
            PH_OPCODE:
            begin
                if (in_beat)
                begin
                    opcode_hold_next = byte_in;
                    phase_next       = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                if (in_beat)
                begin
                    len_next = CntW'(byte_in);
                    if (byte_in == '0)
                    begin
                        phase_next = PH_WAIT_ETX;
                    end
                    else if (9'(byte_in) > 9'(MaxPayload))
                    begin
                        out_valid_next   = 1'b1;
                        kind_next        = sled_pkg::KIND_OVERSIZE;
                        opcode_next      = opcode_hold_reg;
                        payload_len_next = '0;
                        data_byte_next   = '0;
                        byte_index_next  = '0;
                        last_next        = 1'b1;
                        phase_next       = PH_DISCARD;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (in_beat)
                begin
                    payload_wr = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_next >= len_reg)
                    begin
                        phase_next = PH_WAIT_ETX;
                    end
                end
            end
            PH_WAIT_ETX:
            begin
                if (in_beat)
                begin
                    phase_next = PH_WAIT_STX;
                    count_next = '0;
                    if (byte_in == sled_pkg::BYTE_ETX)
                    begin
                        out_valid_next   = 1'b1;
                        kind_next        = sled_pkg::KIND_HEADER;
                        opcode_next      = opcode_hold_reg;
                        payload_len_next = sled_pkg::LEN_W'(len_reg);
                        data_byte_next   = '0;
                        byte_index_next  = '0;
                        last_next        = (len_reg == '0);
                        drain_idx_next   = '0;
                        if (len_reg != '0)
                        begin
                            phase_next = PH_DRAIN;
                        end
                    end
                end
            end
            PH_DISCARD:
            begin
                if (in_beat && byte_in == sled_pkg::BYTE_ETX)
                begin
                    phase_next = PH_WAIT_STX;
                    count_next = '0;
                end
            end
            PH_DRAIN:
            begin
                if (out_free)
                begin
                    drain_shift      = 1'b1;
                    out_valid_next   = 1'b1;
                    kind_next        = sled_pkg::KIND_DATA;
                    opcode_next      = opcode_hold_reg;
                    payload_len_next = sled_pkg::LEN_W'(len_reg);
                    data_byte_next   = cell_q[0];
                    byte_index_next  = sled_pkg::LEN_W'(drain_idx_reg);
                    last_next        = (drain_idx_reg + 1'b1 == len_reg);
                    drain_idx_next   = drain_idx_reg + 1'b1;
                    if (last_next)
                    begin
                        phase_next = PH_WAIT_STX;
                    end
                end
            end
            default:
            begin
                phase_next = PH_WAIT_STX;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_STX;
            count_reg     <= '0;
            len_reg       <= '0;
            drain_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            drain_idx_reg <= drain_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_hold_reg <= opcode_hold_next;
        kind_reg        <= kind_next;
        opcode_reg      <= opcode_next;
        payload_len_reg <= payload_len_next;
        data_byte_reg   <= data_byte_next;
        byte_index_reg  <= byte_index_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign opcode      = opcode_reg;
    assign payload_len = payload_len_reg;
    assign data_byte   = data_byte_reg;
    assign byte_index  = byte_index_reg;
    assign last        = last_reg;

    a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DRAIN |-> !in_ready)
        else $error("input accepted during payload release");

    a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == sled_pkg::KIND_HEADER |-> last_reg == (len_reg == '0))
        else $error("header last flag does not match length");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && kind_reg == sled_pkg::KIND_DATA && !last_reg
        |=> out_valid_reg && kind_reg == sled_pkg::KIND_DATA)
        else $error("payload run broken before last");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> count_reg < len_reg)
        else $error("receive count passed declared length");

endmodule
`default_nettype wire

### design/sled_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module sled_cell (
    input  wire logic                        clk,
    input  wire sled_pkg::cell_ctrl_t        ctrl,
    input  wire logic [sled_pkg::BYTE_W-1:0] wr_data,
    input  wire logic [sled_pkg::BYTE_W-1:0] nbr_data,
    output logic      [sled_pkg::BYTE_W-1:0] q
);

    logic [sled_pkg::BYTE_W-1:0] q_reg;
    logic [sled_pkg::BYTE_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.wr)
        begin
            q_next = wr_data;
        end
        else if (ctrl.shift)
        begin
            q_next = nbr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

### bench/tb_stx_len_etx_command_deframer_core.sv
`timescale 1ns / 1ps
module tb_stx_len_etx_command_deframer_core;

    localparam int unsigned BUF_BYTES   = 32;
    localparam int unsigned MAX_PAYLOAD = BUF_BYTES - 2;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          HOLD_CYCLES = 300;

    typedef enum logic [5:0] {
        HUNT     = 6'b000001,
        GET_OP   = 6'b000010,
        GET_LEN  = 6'b000100,
        GET_DATA = 6'b001000,
        WANT_ETX = 6'b010000,
        SKIP     = 6'b100000
    } deframe_phase_t;

    typedef struct {
        logic [sled_pkg::KIND_W-1:0] kind;
        logic [sled_pkg::BYTE_W-1:0] opcode;
        logic [sled_pkg::LEN_W-1:0]  payload_len;
        logic [sled_pkg::BYTE_W-1:0] data_byte;
        logic [sled_pkg::LEN_W-1:0]  byte_index;
        logic                        last;
    } cmd_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [sled_pkg::BYTE_W-1:0] byte_in;
    logic                        out_valid;
    logic                        out_ready;
    logic [sled_pkg::KIND_W-1:0] kind;
    logic [sled_pkg::BYTE_W-1:0] opcode;
    logic [sled_pkg::LEN_W-1:0]  payload_len;
    logic [sled_pkg::BYTE_W-1:0] data_byte;
    logic [sled_pkg::LEN_W-1:0]  byte_index;
    logic                        res_last;

    stx_len_etx_command_deframer_core #(
        .PAYLOAD_BUFFER_BYTES(BUF_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .opcode      (opcode),
        .payload_len (payload_len),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .last        (res_last)
    );

    // predictor state
    deframe_phase_t              rx_phase;
    int                          rx_count;
    logic [sled_pkg::BYTE_W-1:0] rx_len;
    logic [sled_pkg::BYTE_W-1:0] rx_opcode;
    logic [sled_pkg::BYTE_W-1:0] rx_payload [MAX_PAYLOAD];

    cmd_result_t                 expected_results[$];
    logic [sled_pkg::BYTE_W-1:0] pending_bytes[$];

    int  bytes_queued;
    int  bytes_taken;
    int  results_checked;
    int  frames_closed;
    int  oversize_seen;
    int  frames_dropped;
    int  errors;
    int  idle_cycles;
    int  in_idle_pct;
    int  out_idle_pct;
    int  in_gap_left;
    int  out_gap_left;
    int  out_hold_left;
    int  stall_request;
    bit  in_fire;

    always #5 clk = ~clk;

    function automatic int pick_gap(input int idle_pct);
        int r;
        if ($urandom_range(99) >= idle_pct)
            return 0;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(3, 1);
        if (r < 95)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic push_result(input logic [sled_pkg::KIND_W-1:0] k,
                               input logic [sled_pkg::LEN_W-1:0] len,
                               input logic [sled_pkg::BYTE_W-1:0] data,
                               input logic [sled_pkg::LEN_W-1:0] idx,
                               input logic lst);
        cmd_result_t r;
        r.kind        = k;
        r.opcode      = rx_opcode;
        r.payload_len = len;
        r.data_byte   = data;
        r.byte_index  = idx;
        r.last        = lst;
        expected_results.push_back(r);
    endtask

    task automatic deframe_byte(input logic [sled_pkg::BYTE_W-1:0] b);
        int len;
        case (rx_phase)
            HUNT:
                if (b == sled_pkg::BYTE_STX)
                begin
                    rx_count = 0;
                    rx_phase = GET_OP;
                end
            GET_OP:
            begin
                rx_opcode = b;
                rx_phase  = GET_LEN;
            end
            GET_LEN:
            begin
                rx_len = b;
                if (b == 0)
                    rx_phase = WANT_ETX;
                else if (b > MAX_PAYLOAD)
                begin
                    push_result(sled_pkg::KIND_OVERSIZE, '0, '0, '0, 1'b1);
                    oversize_seen++;
                    rx_phase = SKIP;
                end
                else
                    rx_phase = GET_DATA;
            end
            GET_DATA:
            begin
                if (rx_count < MAX_PAYLOAD)
                begin
                    rx_payload[rx_count] = b;
                    rx_count++;
                end
                if (rx_count >= rx_len)
                    rx_phase = WANT_ETX;
            end
            WANT_ETX:
            begin
                if (b == sled_pkg::BYTE_ETX)
                begin
                    len = (rx_len > MAX_PAYLOAD) ? MAX_PAYLOAD : rx_len;
                    push_result(sled_pkg::KIND_HEADER, sled_pkg::LEN_W'(len), '0, '0,
                                len == 0);
                    for (int i = 0; i < len; i++)
                        push_result(sled_pkg::KIND_DATA, sled_pkg::LEN_W'(len),
                                    rx_payload[i], sled_pkg::LEN_W'(i), i + 1 == len);
                    frames_closed++;
                end
                else
                    frames_dropped++;
                rx_phase = HUNT;
                rx_count = 0;
            end
            SKIP:
                if (b == sled_pkg::BYTE_ETX)
                begin
                    rx_phase = HUNT;
                    rx_count = 0;
                end
            default:
            begin
                rx_phase = HUNT;
                rx_count = 0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v[7:0])
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor, checker and predictor
    always @(posedge clk)
    begin
        cmd_result_t exp_r;
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d opcode %0d",
                             $time, kind, opcode);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("kind", 32'(exp_r.kind), 8'(kind));
                    check_field("opcode", 32'(exp_r.opcode), opcode);
                    check_field("payload_len", 32'(exp_r.payload_len), 8'(payload_len));
                    check_field("data_byte", 32'(exp_r.data_byte), data_byte);
                    check_field("byte_index", 32'(exp_r.byte_index), 8'(byte_index));
                    check_field("last", 32'(exp_r.last), 8'(res_last));
                end
                results_checked++;
            end
            if (in_fire)
            begin
                deframe_byte(byte_in);
                bytes_taken++;
            end
            if (in_fire || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // byte sender
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_fire))
        begin
            if (in_gap_left > 0)
            begin
                in_valid <= 1'b0;
                in_gap_left--;
            end
            else if (pending_bytes.size() != 0)
            begin
                byte_in     <= pending_bytes.pop_front();
                in_valid    <= 1'b1;
                in_gap_left = pick_gap(in_idle_pct);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (stall_request > 0)
            begin
                out_hold_left = stall_request;
                stall_request = 0;
            end
            if (out_hold_left > 0)
            begin
                out_ready <= 1'b0;
                out_hold_left--;
            end
            else if (out_gap_left > 0)
            begin
                out_ready <= 1'b0;
                out_gap_left--;
            end
            else
            begin
                out_ready    <= 1'b1;
                out_gap_left = pick_gap(out_idle_pct);
            end
        end
    end

    task automatic tick();
        @(posedge clk);
        #1;
    endtask

    task automatic queue_byte(input logic [sled_pkg::BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [sled_pkg::BYTE_W-1:0] op, input int len,
                               input logic [sled_pkg::BYTE_W-1:0] close_byte);
        queue_byte(sled_pkg::BYTE_STX);
        queue_byte(op);
        queue_byte(sled_pkg::BYTE_W'(len));
        for (int i = 0; i < len; i++)
            queue_byte(sled_pkg::BYTE_W'($urandom_range(255)));
        queue_byte(close_byte);
    endtask

    task automatic queue_oversize(input logic [sled_pkg::BYTE_W-1:0] op, input int len,
                                  input int junk);
        logic [sled_pkg::BYTE_W-1:0] b;
        queue_byte(sled_pkg::BYTE_STX);
        queue_byte(op);
        queue_byte(sled_pkg::BYTE_W'(len));
        for (int i = 0; i < junk; i++)
        begin
            b = sled_pkg::BYTE_W'($urandom_range(255));
            queue_byte(b == sled_pkg::BYTE_ETX ? 8'hFF : b);
        end
        queue_byte(sled_pkg::BYTE_ETX);
    endtask

    task automatic queue_random_frame();
        int r;
        int len;
        logic [sled_pkg::BYTE_W-1:0] b;
        r = $urandom_range(99);
        if (r < 65)
        begin
            r = $urandom_range(99);
            if (r < 10)
                len = 0;
            else if (r < 65)
                len = $urandom_range(6, 1);
            else if (r < 90)
                len = $urandom_range(MAX_PAYLOAD - 1, 7);
            else
                len = MAX_PAYLOAD;
            queue_frame(sled_pkg::BYTE_W'($urandom_range(255)), len, sled_pkg::BYTE_ETX);
        end
        else if (r < 75)
        begin
            len = $urandom_range(1) ? $urandom_range(40, MAX_PAYLOAD + 1) :
                                      $urandom_range(255, 41);
            queue_oversize(sled_pkg::BYTE_W'($urandom_range(255)), len, $urandom_range(4));
        end
        else if (r < 88)
        begin
            b = sled_pkg::BYTE_W'($urandom_range(255));
            queue_frame(sled_pkg::BYTE_W'($urandom_range(255)), $urandom_range(6),
                        b == sled_pkg::BYTE_ETX ? sled_pkg::BYTE_STX : b);
        end
        else
        begin
            for (int i = $urandom_range(4, 1); i > 0; i--)
            begin
                b = sled_pkg::BYTE_W'($urandom_range(255));
                queue_byte(b == sled_pkg::BYTE_STX ? 8'h00 : b);
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || expected_results.size() != 0)
            tick();
    endtask

    task automatic run_random(input int n_bytes, input int in_pct, input int out_pct);
        int stop_at;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        stop_at      = bytes_queued + n_bytes;
        while (bytes_queued < stop_at)
            queue_random_frame();
        wait_drained();
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        byte_in         = '0;
        out_ready       = 1'b0;
        rx_phase        = HUNT;
        rx_count        = 0;
        rx_len          = '0;
        rx_opcode       = '0;
        bytes_queued    = 0;
        bytes_taken     = 0;
        results_checked = 0;
        frames_closed   = 0;
        oversize_seen   = 0;
        frames_dropped  = 0;
        errors          = 0;
        idle_cycles     = 0;
        in_idle_pct     = 20;
        out_idle_pct    = 20;
        in_gap_left     = 0;
        out_gap_left    = 0;
        out_hold_left   = 0;
        stall_request   = 0;
        in_fire         = 1'b0;
        repeat (12) tick();
        rst_n = 1'b1;

        // noise before STX
        queue_byte(8'h00);
        queue_byte(8'hFF);
        // zero length frame, header only
        queue_frame(8'h00, 0, sled_pkg::BYTE_ETX);
        // one payload byte, all-ones opcode
        queue_byte(sled_pkg::BYTE_STX);
        queue_byte(8'hFF);
        queue_byte(8'h01);
        queue_byte(8'hA5);
        queue_byte(sled_pkg::BYTE_ETX);
        // oversize by one, STX inside the discarded bytes
        queue_byte(sled_pkg::BYTE_STX);
        queue_byte(8'h7E);
        queue_byte(8'(MAX_PAYLOAD + 1));
        queue_byte(sled_pkg::BYTE_STX);
        queue_byte(sled_pkg::BYTE_ETX);
        // STX where ETX belongs: frame dropped, STX not reused
        queue_byte(sled_pkg::BYTE_STX);
        queue_byte(8'h11);
        queue_byte(8'h01);
        queue_byte(sled_pkg::BYTE_ETX);
        queue_byte(sled_pkg::BYTE_STX);
        queue_byte(8'h05);
        wait_drained();

        // receiver holds off while the sender keeps offering
        in_idle_pct  = 0;
        out_idle_pct = 0;
        stall_request = HOLD_CYCLES;
        queue_frame(8'h5A, MAX_PAYLOAD, sled_pkg::BYTE_ETX);
        queue_oversize(8'hC3, 255, 2);
        queue_frame(8'h81, 4, sled_pkg::BYTE_ETX);
        queue_frame(8'h18, 2, sled_pkg::BYTE_ETX);
        wait_drained();

        run_random(70, 30, 30);
        run_random(60, 0, 0);
        run_random(70, 60, 60);

        repeat (20) tick();
        $display("Ran %0d bytes: %0d frames closed, %0d oversize, %0d dropped at ETX.",
                 bytes_taken, frames_closed, oversize_seen, frames_dropped);
        $display("Checked %0d results, %0d mismatches.", results_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### stx_len_etx_command_deframer_core.f
design/sled_pkg.sv
design/sled_cell.sv
design/stx_len_etx_command_deframer_core.sv
bench/tb_stx_len_etx_command_deframer_core.sv
